### rtl/lge_pkg.sv
// shared widths, codes and defaults for the life generation engine
package lge_pkg;

  localparam int DEF_MAX_COLS = 128;
  localparam int DEF_MAX_ROWS = 64;

  localparam int OPCODE_W    = 2;
  localparam int COL_IDX_W   = 7;
  localparam int ROW_IDX_W   = 6;
  localparam int COLS_REG_W  = 8;
  localparam int ROWS_REG_W  = 7;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int NBR_W       = 4;

  localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd120;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd40;

  localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [NBR_W-1:0] KEEP_COUNT  = 4'd2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } cfg_reg_t;

endpackage

### rtl/lge_cmd_if.sv
// request channel carrying one cell command
interface lge_cmd_if
  import lge_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [COL_IDX_W-1:0] col_index;
  logic [ROW_IDX_W-1:0] row_index;
  logic                 cell_in;

  modport source (output valid, opcode, col_index, row_index, cell_in, input ready);
  modport sink   (input valid, opcode, col_index, row_index, cell_in, output ready);
endinterface

### rtl/lge_result_if.sv
// result channel carrying one cell value
interface lge_result_if;
  logic valid;
  logic ready;
  logic cell_out;

  modport source (output valid, cell_out, input ready);
  modport sink   (input valid, cell_out, output ready);
endinterface

### rtl/lge_cfg_if.sv
// configuration write channel
interface lge_cfg_if
  import lge_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### rtl/life_generation_engine.sv
// top level: command sequencer, configuration registers and result register
//
// Use: commands enter on cmd (valid/ready), one at a time. Opcode 0 writes
// one cell, 1 reads one cell, 2 advances the grid in use by one generation,
// 3 does nothing. Every request gives exactly one result on res, cell_out
// holding the cell for a read and 0 otherwise. Sizes are set on cfg, which
// is always ready; write it only while no request is in flight.
// Write and no-op go straight to finish, read via the read state, step via
// prime and the row sweep (skipped with no rows). A step sweeps the store
// one row per cycle: the memory port reads two rows ahead while the rule
// unit writes the current row back, so the row count sets the step time.
// cmd.ready is low from accept until the result is loaded into the output
// register. Reset: sizes return to 120 columns by 40 rows, and a clearing
// pass over all MAX_ROWS rows zeroes the store while cmd.ready stays low.
// A stalled receiver holds the result in the output register; the next
// request is taken meanwhile and waits to load its result until it frees.
module life_generation_engine
  import lge_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic         clk,
  input  logic         rst,
  lge_cmd_if.sink      cmd,
  lge_result_if.source res,
  lge_cfg_if.sink      cfg
);

  localparam int CA_W = $clog2(MAX_COLS);
  localparam int RA_W = $clog2(MAX_ROWS);
  localparam int RC_W = $clog2(MAX_ROWS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PRIME,
    ST_ROW,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [RC_W-1:0]        row_cnt;
  logic [MAX_COLS-1:0]    prev_row;
  logic [MAX_COLS-1:0]    cur_row;
  logic [CA_W-1:0]        rd_col;
  logic                   rd_inside;
  logic                   res_bit;
  logic                   out_valid;
  logic                   cell_out;
  logic [COLS_REG_W-1:0]  cols_in_use;
  logic [ROWS_REG_W-1:0]  rows_in_use;

  logic                   cmd_fire;
  op_t                    op;
  logic                   in_grid;
  logic                   res_load;
  logic [RC_W-1:0]        rows_eff;
  logic [RC_W:0]          row_plus1;
  logic [RC_W:0]          row_plus2;
  logic [MAX_COLS-1:0]    col_mask;
  logic [MAX_COLS-1:0]    next_row;
  logic [MAX_COLS-1:0]    new_row;

  logic                   mem_we;
  logic [RA_W-1:0]        mem_waddr;
  logic [MAX_COLS-1:0]    mem_wmask;
  logic [MAX_COLS-1:0]    mem_wdata;
  logic                   mem_re;
  logic [RA_W-1:0]        mem_raddr;
  logic [MAX_COLS-1:0]    mem_rdata;

  assign cmd.ready    = (state == ST_IDLE);
  assign cmd_fire     = cmd.valid && cmd.ready;
  assign op           = op_t'(cmd.opcode);
  assign cfg.ready    = 1'b1;
  assign res.valid    = out_valid;
  assign res.cell_out = cell_out;
  assign res_load     = (state == ST_FINISH) && (!out_valid || res.ready);

  assign rows_eff = (int'(rows_in_use) > MAX_ROWS) ? RC_W'(MAX_ROWS) : RC_W'(rows_in_use);

  assign in_grid = (int'(cmd.col_index) < int'(cols_in_use))
                && (int'(cmd.col_index) < MAX_COLS)
                && (int'(cmd.row_index) < int'(rows_eff));

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign col_mask[c] = (int'(cols_in_use) > c);
  end

  assign row_plus1 = {1'b0, row_cnt} + (RC_W+1)'(1);
  assign row_plus2 = {1'b0, row_cnt} + (RC_W+1)'(2);
  assign next_row  = (row_plus1 < {1'b0, rows_eff}) ? mem_rdata : '0;

  lge_grid_mem #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wmask (mem_wmask),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lge_row_rule #(
    .MAX_COLS (MAX_COLS)
  ) u_rule (
    .prev_row (prev_row),
    .cur_row  (cur_row),
    .next_row (next_row),
    .col_mask (col_mask),
    .new_row  (new_row)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = RA_W'(row_cnt);
    mem_wmask = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wmask = '1;
      end
      ST_IDLE: begin
        if (cmd_fire) begin
          unique case (op)
            OP_WRITE: begin
              mem_we    = in_grid;
              mem_waddr = RA_W'(cmd.row_index);
              mem_wmask = MAX_COLS'(1) << cmd.col_index;
              mem_wdata = {MAX_COLS{cmd.cell_in}};
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = RA_W'(cmd.row_index);
            end
            OP_STEP: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
            OP_NOP: ;
          endcase
        end
      end
      ST_PRIME: begin
        mem_re    = 1'b1;
        mem_raddr = RA_W'(1);
      end
      ST_ROW: begin
        mem_we    = 1'b1;
        mem_wmask = col_mask;
        mem_wdata = new_row;
        mem_re    = 1'b1;
        mem_raddr = RA_W'(row_plus2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      row_cnt     <= '0;
      out_valid   <= 1'b0;
      cols_in_use <= COLS_RESET;
      rows_in_use <= ROWS_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_reg_t'(cfg.addr))
          REG_COLS: cols_in_use <= COLS_REG_W'(cfg.data);
          REG_ROWS: rows_in_use <= ROWS_REG_W'(cfg.data);
        endcase
      end
      priority if (res_load) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (row_cnt == RC_W'(MAX_ROWS - 1)) begin
            row_cnt <= '0;
            state   <= ST_IDLE;
          end else begin
            row_cnt <= row_cnt + RC_W'(1);
          end
        end
        ST_IDLE: begin
          if (cmd_fire) begin
            res_bit <= 1'b0;
            unique case (op)
              OP_READ: begin
                rd_col    <= CA_W'(cmd.col_index);
                rd_inside <= in_grid;
                state     <= ST_READ;
              end
              OP_STEP: begin
                prev_row <= '0;
                row_cnt  <= '0;
                state    <= (rows_eff == '0) ? ST_FINISH : ST_PRIME;
              end
              OP_WRITE, OP_NOP: state <= ST_FINISH;
            endcase
          end
        end
        ST_READ: begin
          res_bit <= rd_inside & mem_rdata[rd_col];
          state   <= ST_FINISH;
        end
        ST_PRIME: begin
          cur_row <= mem_rdata;
          state   <= ST_ROW;
        end
        ST_ROW: begin
          prev_row <= cur_row;
          cur_row  <= next_row;
          row_cnt  <= row_plus1[RC_W-1:0];
          if (row_plus1 == {1'b0, rows_eff}) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (res_load) begin
            cell_out <= res_bit;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("request accepted while another is in flight");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROW |-> row_cnt < rows_eff)
    else $error("row sweep beyond the grid in use");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result loaded outside the finish state");

  a_write_only_inside: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && mem_we |-> cmd_fire && op == OP_WRITE && in_grid)
    else $error("cell write outside the grid in use");

endmodule

### rtl/lge_grid_mem.sv
// grid store, one row per word, bit write mask, registered read
module lge_grid_mem
  import lge_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(MAX_ROWS)-1:0] waddr,
  input  logic [MAX_COLS-1:0]         wmask,
  input  logic [MAX_COLS-1:0]         wdata,
  input  logic                        re,
  input  logic [$clog2(MAX_ROWS)-1:0] raddr,
  output logic [MAX_COLS-1:0]         rdata
);

  logic [MAX_COLS-1:0] mem [MAX_ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < MAX_COLS; b++) begin
        if (wmask[b]) begin
          mem[waddr][b] <= wdata[b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/lge_row_rule.sv
// life rule for one whole row from the old rows above, at and below
module lge_row_rule
  import lge_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic [MAX_COLS-1:0] prev_row,
  input  logic [MAX_COLS-1:0] cur_row,
  input  logic [MAX_COLS-1:0] next_row,
  input  logic [MAX_COLS-1:0] col_mask,
  output logic [MAX_COLS-1:0] new_row
);

  logic [MAX_COLS+1:0] pp;
  logic [MAX_COLS+1:0] cp;
  logic [MAX_COLS+1:0] np;

  // columns outside the grid in use count as dead
  assign pp = {1'b0, prev_row & col_mask, 1'b0};
  assign cp = {1'b0, cur_row & col_mask, 1'b0};
  assign np = {1'b0, next_row & col_mask, 1'b0};

  always_comb begin
    logic [NBR_W-1:0] n;
    n = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      n = NBR_W'(pp[c]) + NBR_W'(pp[c+1]) + NBR_W'(pp[c+2])
        + NBR_W'(cp[c]) + NBR_W'(cp[c+2])
        + NBR_W'(np[c]) + NBR_W'(np[c+1]) + NBR_W'(np[c+2]);
      new_row[c] = (n == BIRTH_COUNT) || ((n == KEEP_COUNT) && cur_row[c]);
    end
  end

endmodule
